// ===== rtl/core/ccrf_pkg.sv =====
// ccrf_pkg: constants and reading check functions for the checked reading framer
// no dependencies; imported by crc_checked_reading_framer_top

package ccrf_pkg;

    // frame layout
    localparam logic [7:0] FRAME_SYNC1 = 8'hAB;
    localparam logic [7:0] FRAME_SYNC2 = 8'h3C;
    localparam logic [7:0] FRAME_CMD   = 8'h12;
    localparam logic [7:0] FRAME_LEN   = 8'h04;

    // sum of the four fixed header bytes, mod 256
    localparam logic [7:0] HDR_SUM = 8'(FRAME_SYNC1 + FRAME_SYNC2 + FRAME_CMD + FRAME_LEN);

    // byte positions within a frame
    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned POS_W = $clog2(FRAME_BYTES);
    typedef logic [POS_W-1:0] t_pos;
    localparam t_pos POS_SYNC1 = t_pos'(0);
    localparam t_pos POS_SYNC2 = t_pos'(1);
    localparam t_pos POS_CMD   = t_pos'(2);
    localparam t_pos POS_LEN   = t_pos'(3);
    localparam t_pos POS_HUM_L = t_pos'(4);
    localparam t_pos POS_HUM_H = t_pos'(5);
    localparam t_pos POS_TMP_L = t_pos'(6);
    localparam t_pos POS_TMP_H = t_pos'(7);
    localparam t_pos POS_CSUM  = t_pos'(8);

    // crc-8, x^8+x^5+x^4+1, msb first, init 0
    localparam logic [8:0]  CRC_POLY    = 9'h131;
    localparam logic [7:0]  CRC_TOP_BIT = 8'h80;
    localparam logic [15:0] BAD_VALUE   = 16'hFFFF;

    typedef logic [15:0] t_value;

    // one byte through the crc register
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP_BIT) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY[7:0];
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // a reading is good when acked, crc matches and value is not all ones
    function automatic logic reading_good(input logic ack, input logic [7:0] msb,
                                          input logic [7:0] lsb, input logic [7:0] crc);
        logic [7:0] calc;
        calc = crc8_byte(crc8_byte(8'h00, msb), lsb);
        return ack && (calc == crc) && ({msb, lsb} != BAD_VALUE);
    endfunction

endpackage

// ===== rtl/core/ccrf_in_if.sv =====
// ccrf_in_if: valid/ready channel carrying one pair of raw sensor readings
// no dependencies

interface ccrf_in_if;
    logic       valid;
    logic       ready;
    logic       hum_ack_ok;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;
    logic [7:0] hum_crc;
    logic       tmp_ack_ok;
    logic [7:0] tmp_msb;
    logic [7:0] tmp_lsb;
    logic [7:0] tmp_crc;

    modport source (
        output valid, hum_ack_ok, hum_msb, hum_lsb, hum_crc,
               tmp_ack_ok, tmp_msb, tmp_lsb, tmp_crc,
        input  ready
    );

    modport sink (
        input  valid, hum_ack_ok, hum_msb, hum_lsb, hum_crc,
               tmp_ack_ok, tmp_msb, tmp_lsb, tmp_crc,
        output ready
    );
endinterface

// ===== rtl/core/ccrf_out_if.sv =====
// ccrf_out_if: valid/ready channel carrying one frame byte per beat
// no dependencies

interface ccrf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (
        output valid, frame_byte, last_byte,
        input  ready
    );

    modport sink (
        input  valid, frame_byte, last_byte,
        output ready
    );
endinterface

// ===== rtl/core/crc_checked_reading_framer_top.sv =====
// Checked reading framer. Each input beat carries a humidity and a temperature reading; each
// reading is checked (ack, crc-8 poly 0x31 over high then low byte, value not 0xFFFF) and a
// failed reading is replaced by the last good one (0 after reset). Every input beat yields a
// nine-byte frame AB 3C 12 04 hum_l hum_h tmp_l tmp_h csum, one byte per output beat, with
// last_byte set on the checksum. An input beat is held in an input register, checked and
// framed in one pass into a frame register, then sent out; the next input beat is taken while
// the current frame drains. Sustained throughput is set by the byte-wide output channel.
// depends on: ccrf_pkg, ccrf_in_if, ccrf_out_if

module crc_checked_reading_framer_top
    import ccrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccrf_in_if.sink     i_item,
    ccrf_out_if.source  o_frame
);

    // input register
    logic       r_in_vld;
    logic       r_hum_ack;
    logic [7:0] r_hum_msb;
    logic [7:0] r_hum_lsb;
    logic [7:0] r_hum_crc;
    logic       r_tmp_ack;
    logic [7:0] r_tmp_msb;
    logic [7:0] r_tmp_lsb;
    logic [7:0] r_tmp_crc;

    // held last good values
    t_value r_held_hum;
    t_value r_held_tmp;

    // frame register and byte position
    logic       r_out_vld;
    t_pos       r_pos;
    t_value     r_hum;
    t_value     r_tmp;
    logic [7:0] r_csum;

    logic       hum_good;
    logic       tmp_good;
    t_value     n_hum;
    t_value     n_tmp;
    logic [7:0] n_csum;
    logic       out_take;
    logic       frame_done;
    logic       load;
    logic       in_take;
    logic       is_last;

    // handshake control
    assign is_last    = (r_pos == POS_CSUM);
    assign out_take   = r_out_vld && o_frame.ready;
    assign frame_done = out_take && is_last;
    assign load       = r_in_vld && (!r_out_vld || frame_done);
    assign i_item.ready = !r_in_vld || load;
    assign in_take    = i_item.valid && i_item.ready;

    // check readings and build frame contents
    always_comb begin
        hum_good = reading_good(r_hum_ack, r_hum_msb, r_hum_lsb, r_hum_crc);
        tmp_good = reading_good(r_tmp_ack, r_tmp_msb, r_tmp_lsb, r_tmp_crc);
        n_hum    = hum_good ? {r_hum_msb, r_hum_lsb} : r_held_hum;
        n_tmp    = tmp_good ? {r_tmp_msb, r_tmp_lsb} : r_held_tmp;
        n_csum   = HDR_SUM + n_hum[7:0] + n_hum[15:8] + n_tmp[7:0] + n_tmp[15:8];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_hum_ack <= i_item.hum_ack_ok;
            r_hum_msb <= i_item.hum_msb;
            r_hum_lsb <= i_item.hum_lsb;
            r_hum_crc <= i_item.hum_crc;
            r_tmp_ack <= i_item.tmp_ack_ok;
            r_tmp_msb <= i_item.tmp_msb;
            r_tmp_lsb <= i_item.tmp_lsb;
            r_tmp_crc <= i_item.tmp_crc;
        end
    end

    // held values update as each item is framed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_hum <= '0;
            r_held_tmp <= '0;
        end else if (load) begin
            r_held_hum <= n_hum;
            r_held_tmp <= n_tmp;
        end
    end

    // frame register and output byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pos     <= POS_SYNC1;
        end else if (load) begin
            r_out_vld <= 1'b1;
            r_pos     <= POS_SYNC1;
        end else if (frame_done) begin
            r_out_vld <= 1'b0;
            r_pos     <= POS_SYNC1;
        end else if (out_take) begin
            r_pos     <= r_pos + t_pos'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hum  <= n_hum;
            r_tmp  <= n_tmp;
            r_csum <= n_csum;
        end
    end

    // output byte select
    always_comb begin
        case (r_pos)
            POS_SYNC1: o_frame.frame_byte = FRAME_SYNC1;
            POS_SYNC2: o_frame.frame_byte = FRAME_SYNC2;
            POS_CMD:   o_frame.frame_byte = FRAME_CMD;
            POS_LEN:   o_frame.frame_byte = FRAME_LEN;
            POS_HUM_L: o_frame.frame_byte = r_hum[7:0];
            POS_HUM_H: o_frame.frame_byte = r_hum[15:8];
            POS_TMP_L: o_frame.frame_byte = r_tmp[7:0];
            POS_TMP_H: o_frame.frame_byte = r_tmp[15:8];
            default:   o_frame.frame_byte = r_csum;
        endcase
    end

    assign o_frame.valid     = r_out_vld;
    assign o_frame.last_byte = is_last;

    // a frame never stops short of its checksum beat
    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && o_frame.ready && !o_frame.last_byte) |=> o_frame.valid)
        else $error("frame ended before checksum beat");

    // a newly loaded frame starts with the first sync byte
    a_frame_starts_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_frame.valid && (o_frame.frame_byte == FRAME_SYNC1) && !o_frame.last_byte))
        else $error("new frame does not start with sync byte");

    // the all-ones value is never taken as a good reading
    a_held_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_hum != BAD_VALUE) && (r_held_tmp != BAD_VALUE))
        else $error("held value is all ones");

endmodule
